>>> rtl/core/bss_pkg.sv
// Shared types and constants for the bounded sorted set.
// Holds the result codes, the cell command and the controller states.
// No dependencies.
`default_nettype none
package bss_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ELEMENT   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  key;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_INSERT,
    FSM_DRAIN
  } fsm_t;

endpackage
`default_nettype wire

>>> rtl/core/bss_cell.sv
// One cell of the sorted chain: one stored entry, its valid flag and compare flags.
// Depends on bss_pkg.
`default_nettype none
module bss_cell (
  input  wire                                clk,
  input  wire                                rst,
  input  bss_pkg::cell_cmd_t                 cmd,
  input  wire signed [bss_pkg::DATA_W-1:0]   left_data,
  input  wire                                left_valid,
  input  wire                                left_lt,
  input  wire signed [bss_pkg::DATA_W-1:0]   right_data,
  input  wire                                right_valid,
  input  wire signed [bss_pkg::DATA_W-1:0]   head_data,
  output logic signed [bss_pkg::DATA_W-1:0]  data,
  output logic                               valid,
  output logic                               lt,
  output logic                               eq
);
  import bss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      case (cmd.op)
        CELL_CMP: begin
          lt <= valid && (data < cmd.key);
          eq <= valid && (data == cmd.key);
        end
        CELL_INSERT: begin
          if (!lt) begin
            valid <= left_valid;
          end
          lt <= 1'b0;
          eq <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (!lt) begin
          data <= left_lt ? cmd.key : left_data;
        end
      end
      CELL_ROTATE: begin
        if (valid) begin
          data <= right_valid ? right_data : head_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/bss_chain.sv
// Row of sorted cells; inserts shift the upper part right, drains rotate left.
// Depends on bss_pkg and bss_cell.
`default_nettype none
module bss_chain #(
  parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  bss_pkg::cell_cmd_t                 cmd,
  output logic signed [bss_pkg::DATA_W-1:0]  head,
  output logic                               dup,
  output logic                               full
);
  import bss_pkg::*;

  logic signed [DATA_W-1:0] data [CAPACITY];
  logic [CAPACITY-1:0]      valid;
  logic [CAPACITY-1:0]      lt;
  logic [CAPACITY-1:0]      eq;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic                     left_valid;
    logic                     left_lt;
    logic signed [DATA_W-1:0] right_data;
    logic                     right_valid;

    if (i == 0) begin : g_first
      assign left_data  = '0;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_data  = data[i-1];
      assign left_valid = valid[i-1];
      assign left_lt    = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_data  = data[i+1];
      assign right_valid = valid[i+1];
    end

    bss_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .left_lt     (left_lt),
      .right_data  (right_data),
      .right_valid (right_valid),
      .head_data   (data[0]),
      .data        (data[i]),
      .valid       (valid[i]),
      .lt          (lt[i]),
      .eq          (eq[i])
    );
  end

  assign head = data[0];
  assign dup  = |eq;
  assign full = valid[CAPACITY-1];

endmodule
`default_nettype wire

>>> rtl/core/bounded_sorted_set_top.sv
// Bounded sorted set: top level with the command controller and result register.
// Depends on bss_pkg and bss_chain. Synchronous reset empties the set.
// Insert: one beat, registered in INSERT after the compare, taken at the same edge as
// the next start (compare over all cells, then one shift step if new and not full).
// Drain of n entries: n beats on consecutive cycles, each taken from the head in DRAIN
// as the chain rotates one cell per cycle; empty drain: one beat next cycle.
`default_nettype none
module bounded_sorted_set_top #(
  parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                opcode,
  input  wire signed [bss_pkg::DATA_W-1:0]   value,
  output logic                               strobe,
  output logic [2:0]                         status,
  output logic signed [bss_pkg::DATA_W-1:0]  element,
  output logic                               last
);
  import bss_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  fsm_t                     state;
  fsm_t                     state_next;
  logic signed [DATA_W-1:0] key;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] head;
  logic                     dup;
  logic                     full;
  logic                     accept;
  logic                     drain_end;

  assign accept    = start && !busy;
  assign drain_end = (idx == count - CNT_W'(1));

  bss_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head),
    .dup  (dup),
    .full (full)
  );

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (start && !opcode) begin
          state_next = FSM_INSERT;
        end else if (start && opcode && (count != '0)) begin
          state_next = FSM_DRAIN;
        end
      end
      FSM_INSERT: begin
        state_next = FSM_IDLE;
      end
      FSM_DRAIN: begin
        if (drain_end) begin
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    cmd.op  = CELL_HOLD;
    cmd.key = key;
    case (state)
      FSM_IDLE: begin
        busy = 1'b0;
        if (start && !opcode) begin
          cmd.op  = CELL_CMP;
          cmd.key = value;
        end
      end
      FSM_INSERT: begin
        if (!dup && !full) begin
          cmd.op = CELL_INSERT;
        end
      end
      FSM_DRAIN: begin
        cmd.op = CELL_ROTATE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FSM_IDLE;
      count  <= '0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        FSM_IDLE: begin
          idx <= '0;
          if (accept && opcode && (count == '0)) begin
            strobe <= 1'b1;
          end
        end
        FSM_INSERT: begin
          strobe <= 1'b1;
          if (!dup && !full) begin
            count <= count + CNT_W'(1);
          end
        end
        FSM_DRAIN: begin
          strobe <= 1'b1;
          idx    <= idx + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= value;
    end
    case (state)
      FSM_IDLE: begin
        status  <= ST_EMPTY;
        element <= '0;
        last    <= 1'b1;
      end
      FSM_INSERT: begin
        element <= '0;
        last    <= 1'b1;
        if (full) begin
          status <= ST_FULL;
        end else if (dup) begin
          status <= ST_DUPLICATE;
        end else begin
          status <= ST_INSERTED;
        end
      end
      FSM_DRAIN: begin
        status  <= ST_ELEMENT;
        element <= head;
        last    <= drain_end;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
